// File: src/rcfe_pkg.sv
// Shared types and constants of the radio command frame encoder.
package rcfe_pkg;

  localparam int unsigned FreqWidth         = 32;
  localparam int unsigned DecimalBase       = 10;
  localparam int unsigned BcdDigits         = 10;
  localparam int unsigned BcdWidth          = 4 * BcdDigits;
  localparam int unsigned PairCount         = BcdDigits / 2;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] PreambleByte  = 8'hFE;
  localparam logic [7:0] EndByte       = 8'hFD;
  localparam logic [7:0] RadioAddrRst  = 8'h00;
  localparam logic [7:0] CtrlAddrRst   = 8'hE0;

  // Configuration register indexes
  localparam logic CfgRadioAddr = 1'b0;
  localparam logic CfgCtrlAddr  = 1'b1;

  // Payload kinds
  localparam logic FuncFreq = 1'b0;
  localparam logic FuncData = 1'b1;

  // Classified request handed from front to back; payload holds either the
  // packed BCD frequency (low pair first) or the raw byte in bits [7:0].
  typedef struct packed {
    logic                func;
    logic [7:0]          command;
    logic                has_subcommand;
    logic [7:0]          subcommand;
    logic [BcdWidth-1:0] payload;
  } req_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_HOLD = 3'b100
  } front_state_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PRE0  = 9'b000000010,
    S_PRE1  = 9'b000000100,
    S_RADDR = 9'b000001000,
    S_CADDR = 9'b000010000,
    S_CMD   = 9'b000100000,
    S_SUB   = 9'b001000000,
    S_PAY   = 9'b010000000,
    S_END   = 9'b100000000
  } back_state_e;

endpackage

// File: src/rcfe_if.sv
// Handshake channels of the radio command frame encoder.
interface rcfe_cmd_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  command;
  logic        has_subcommand;
  logic [7:0]  subcommand;
  logic [31:0] frequency_hz;
  logic [7:0]  data_byte;

  modport source (
    output valid, func, command, has_subcommand, subcommand, frequency_hz, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, command, has_subcommand, subcommand, frequency_hz, data_byte,
    output ready
  );
endinterface

interface rcfe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

// File: src/radio_command_frame_encoder_core.sv
// A request goes from the front-end hold register through the queue and the sequencer
// state into the output register; a frequency request first runs the BCD converter,
// 4 bits per step. Throughput: one frame byte per cycle while frame_o.ready is high,
// frames back to back while requests wait in the queue. The front end takes a new
// request only as it pushes the previous one. Reset (async, active low) empties the
// queue and output register, sets the radio address to 0x00 and the controller address to 0xE0.
module radio_command_frame_encoder_core #(
  parameter int unsigned QueueDepth = rcfe_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  rcfe_cmd_if.sink   req_i,
  rcfe_frame_if.source frame_o
);
  import rcfe_pkg::*;

  logic [7:0] radio_addr_q;
  logic [7:0] ctrl_addr_q;
  logic       push_valid;
  logic       push_ready;
  req_t       push_data;
  logic       pop_valid;
  logic       pop_ready;
  req_t       pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radio_addr_q <= RadioAddrRst;
      ctrl_addr_q  <= CtrlAddrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadioAddr: radio_addr_q <= cfg_data_i;
        CfgCtrlAddr:  ctrl_addr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rcfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rcfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radio_addr_i (radio_addr_q),
    .ctrl_addr_i  (ctrl_addr_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .frame_o      (frame_o)
  );

endmodule

// File: src/rcfe_front.sv
// Front end: accepts requests, converts frequencies to packed BCD and passes raw bytes through.
module rcfe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  rcfe_cmd_if.sink      req_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output rcfe_pkg::req_t push_data_o
);
  import rcfe_pkg::*;

  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps   = FreqWidth / BitsPerStep;
  localparam int unsigned CntW        = $clog2(ConvSteps);

  front_state_e        state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [FreqWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d;
  logic                func_q, func_d;
  logic [7:0]          cmd_q, cmd_d;
  logic                has_sub_q, has_sub_d;
  logic [7:0]          sub_q, sub_d;
  logic [BcdWidth-1:0] dab_bcd;
  logic [FreqWidth-1:0] dab_bin;
  logic                accept;
  logic                push;

  // Double dabble, a few bits per cycle
  always_comb begin
    logic [BcdWidth-1:0]  b;
    logic [FreqWidth-1:0] v;
    b = bcd_q;
    v = bin_q;
    for (int k = 0; k < BitsPerStep; k++) begin
      for (int d = 0; d < BcdDigits; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BcdWidth-2:0], v[FreqWidth-1]};
      v = {v[FreqWidth-2:0], 1'b0};
    end
    dab_bcd = b;
    dab_bin = v;
  end

  assign push         = (state_q == F_HOLD) && push_ready_i;
  assign req_i.ready  = (state_q == F_IDLE) || push;
  assign accept       = req_i.valid && req_i.ready;
  assign push_valid_o = (state_q == F_HOLD);

  assign push_data_o.func           = func_q;
  assign push_data_o.command        = cmd_q;
  assign push_data_o.has_subcommand = has_sub_q;
  assign push_data_o.subcommand     = sub_q;
  assign push_data_o.payload        = bcd_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    func_d    = func_q;
    cmd_d     = cmd_q;
    has_sub_d = has_sub_q;
    sub_d     = sub_q;
    if (accept) begin
      func_d    = req_i.func;
      cmd_d     = req_i.command;
      has_sub_d = req_i.has_subcommand;
      sub_d     = req_i.subcommand;
      cnt_d     = '0;
      if (req_i.func == FuncData) begin
        bcd_d   = {{(BcdWidth-8){1'b0}}, req_i.data_byte};
        bin_d   = '0;
        state_d = F_HOLD;
      end else begin
        bcd_d   = '0;
        bin_d   = req_i.frequency_hz;
        state_d = F_CONV;
      end
    end else begin
      unique case (state_q)
        F_IDLE: ;
        F_CONV: begin
          bcd_d = dab_bcd;
          bin_d = dab_bin;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == CntW'(ConvSteps - 1)) begin
            state_d = F_HOLD;
          end
        end
        F_HOLD: begin
          if (push) begin
            state_d = F_IDLE;
          end
        end
        default: state_d = F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    func_q    <= func_d;
    cmd_q     <= cmd_d;
    has_sub_q <= has_sub_d;
    sub_q     <= sub_d;
  end

endmodule

// File: src/rcfe_queue.sv
// Short request queue between the front end and the frame sequencer.
module rcfe_queue #(
  parameter int unsigned Depth = rcfe_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rcfe_pkg::req_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rcfe_pkg::req_t pop_data_o
);
  import rcfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/rcfe_back.sv
// Back end: walks one request through the frame bytes into an output register.
module rcfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     radio_addr_i,
  input  logic [7:0]     ctrl_addr_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  rcfe_pkg::req_t pop_data_i,
  rcfe_frame_if.source   frame_o
);
  import rcfe_pkg::*;

  localparam int unsigned PairW = $clog2(PairCount);

  back_state_e      state_q, state_d, nxt;
  req_t             cur_q, cur_d;
  logic [PairW-1:0] pair_q, pair_d;
  logic             ov_q, ov_d;
  logic [7:0]       byte_q, byte_d, byte_sel;
  logic             last_q, last_d, last_sel;
  logic             load_en;

  assign load_en     = (state_q != S_IDLE) && (!ov_q || frame_o.ready);
  assign pop_ready_o = (state_q == S_IDLE) || (load_en && (state_q == S_END));

  always_comb begin
    byte_sel = PreambleByte;
    last_sel = 1'b0;
    nxt      = state_q;
    unique case (state_q)
      S_IDLE: nxt = S_IDLE;
      S_PRE0: nxt = S_PRE1;
      S_PRE1: nxt = S_RADDR;
      S_RADDR: begin
        byte_sel = radio_addr_i;
        nxt      = S_CADDR;
      end
      S_CADDR: begin
        byte_sel = ctrl_addr_i;
        nxt      = S_CMD;
      end
      S_CMD: begin
        byte_sel = cur_q.command;
        nxt      = cur_q.has_subcommand ? S_SUB : S_PAY;
      end
      S_SUB: begin
        byte_sel = cur_q.subcommand;
        nxt      = S_PAY;
      end
      S_PAY: begin
        byte_sel = cur_q.payload[7:0];
        if ((cur_q.func == FuncData) || (pair_q == PairW'(PairCount - 1))) begin
          nxt = S_END;
        end
      end
      S_END: begin
        byte_sel = EndByte;
        last_sel = 1'b1;
        nxt      = S_IDLE;
      end
      default: nxt = S_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    pair_d  = pair_q;
    if (pop_valid_i && pop_ready_o) begin
      state_d = S_PRE0;
      cur_d   = pop_data_i;
      pair_d  = '0;
    end else if (load_en) begin
      state_d = nxt;
      if (state_q == S_PAY) begin
        // drop the pair just sent
        cur_d.payload = {8'h00, cur_q.payload[BcdWidth-1:8]};
        pair_d        = pair_q + PairW'(1);
      end
    end
  end

  always_comb begin
    ov_d   = ov_q;
    byte_d = byte_q;
    last_d = last_q;
    if (load_en) begin
      ov_d   = 1'b1;
      byte_d = byte_sel;
      last_d = last_sel;
    end else if (frame_o.ready) begin
      ov_d = 1'b0;
    end
  end

  assign frame_o.valid      = ov_q;
  assign frame_o.frame_byte = byte_q;
  assign frame_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pair_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pair_q  <= pair_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

endmodule

// File: src/rcfe_checker.sv
// Port-level checks of the frame encoder, bound to the top level.
module rcfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_func_i,
  input logic       frame_valid_i,
  input logic       frame_ready_i,
  input logic [7:0] frame_byte_i,
  input logic       frame_last_i
);
  import rcfe_pkg::*;

  // hold a stalled beat
  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && !frame_ready_i |=>
      frame_valid_i && $stable(frame_byte_i) && $stable(frame_last_i))
    else $error("stalled frame beat changed");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && frame_last_i |-> frame_byte_i == EndByte)
    else $error("last set on a byte other than the end byte");

  // a frame that directly follows an accepted end byte opens with a preamble byte
  a_next_frame_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && frame_ready_i && frame_last_i |=>
      !frame_valid_i || (frame_byte_i == PreambleByte && !frame_last_i))
    else $error("frame did not start with a preamble byte");

  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_func_i == FuncFreq |=> !req_ready_i)
    else $error("request taken while frequency conversion runs");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !frame_valid_i)
    else $error("frame beat valid during reset");

endmodule

bind radio_command_frame_encoder_core rcfe_checker u_rcfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_func_i    (req_i.func),
  .frame_valid_i (frame_o.valid),
  .frame_ready_i (frame_o.ready),
  .frame_byte_i  (frame_o.frame_byte),
  .frame_last_i  (frame_o.last)
);
